[design/firmware_script_i2c_loader_defines.svh]
// Assertion macros used by the loader top-level design file.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef FIRMWARE_SCRIPT_I2C_LOADER_DEFINES_SVH
`define FIRMWARE_SCRIPT_I2C_LOADER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define FSIL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("loader assertion failed");

// Next-cycle implication, checked only outside reset.
`define FSIL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("loader assertion failed");

`endif

[design/fsil_pkg.sv]
`timescale 1ns / 1ps
package fsil_pkg;

	// Message limit default, its hard cap and its minimum.
	localparam int MAX_MESSAGE_DEFAULT = 64;
	localparam int MSG_LIMIT_CAP       = 64;
	localparam int MSG_LIMIT_MIN       = 2;

	// Configuration register map.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 20;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_BYTES = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE = 1'd1;
	localparam logic [6:0] MAX_MESSAGE_RESET = 7'd64;

	// Special tokens.
	localparam logic [15:0] TOK_DONE   = 16'hffff;
	localparam logic [15:0] TOK_CRESET = 16'hff00;
	localparam logic [15:0] TOK_TRESET = 16'h0000;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_I2C    = 3'd0,
		KIND_TRESET = 3'd1,
		KIND_CRESET = 3'd2,
		KIND_SLEEP  = 3'd3,
		KIND_FLUSH  = 3'd4,
		KIND_DONE   = 3'd5,
		KIND_ERROR  = 3'd6
	} kind_t;

	// Error codes.
	localparam logic [1:0] ERR_TRUNCATED = 2'd0;
	localparam logic [1:0] ERR_BAD_RESET = 2'd1;
	localparam logic [1:0] ERR_OVERRUN   = 2'd2;

	// Token parser phase.
	typedef enum logic [1:0] {
		PH_LOW  = 2'd0,
		PH_HIGH = 2'd1,
		PH_REG  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  bus_byte;
		logic        message_end;
		logic [14:0] sleep_ms;
		logic [1:0]  error_code;
		logic        last_of_run;
	} result_t;

	// Results caused by one input byte, handed from decoder to output queue.
	localparam int MAX_RESULTS = 4;
	typedef struct packed {
		logic [2:0]                  count;
		result_t [MAX_RESULTS-1:0]   res;
	} result_group_t;

	// Builds a result with last_of_run cleared.
	function automatic result_t mk_res(kind_t k, logic [7:0] bb, logic me,
			logic [14:0] sl, logic [1:0] ec);
		result_t r;
		r.kind        = k;
		r.bus_byte    = bb;
		r.message_end = me;
		r.sleep_ms    = sl;
		r.error_code  = ec;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

[design/fsil_decode.sv]
`timescale 1ns / 1ps
module fsil_decode #(
	parameter int MAX_MESSAGE = fsil_pkg::MAX_MESSAGE_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              b,
	input  logic [19:0]             image_bytes,
	input  logic [6:0]              max_message_bytes,
	output fsil_pkg::result_group_t grp
);

	localparam int LIM_MAX = (MAX_MESSAGE < fsil_pkg::MSG_LIMIT_CAP) ?
		MAX_MESSAGE : fsil_pkg::MSG_LIMIT_CAP;
	localparam int CHUNK_W = (LIM_MAX > 2) ? $clog2(LIM_MAX) : 1;

	fsil_pkg::phase_t phase_q, phase_d;
	logic [7:0]         token_low_q, token_low_d;
	logic [14:0]        block_rem_q, block_rem_d;
	logic [7:0]         reg_byte_q, reg_byte_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;
	logic [19:0]        consumed_q, consumed_d;
	logic               halted_q, halted_d;

	logic [15:0]        tok;
	logic [19:0]        remain;
	logic               at_end;
	logic [14:0]        rem_dec;
	logic [CHUNK_W:0]   fill_inc;
	logic [6:0]         lim;
	logic               mend;
	logic [2:0]         n;

	// Effective message limit after clamping.
	always_comb begin
		lim = max_message_bytes;
		if (lim < 7'(fsil_pkg::MSG_LIMIT_MIN)) lim = 7'(fsil_pkg::MSG_LIMIT_MIN);
		if (lim > 7'(LIM_MAX)) lim = 7'(LIM_MAX);
	end

	// Next state and the results caused by the current byte.
	always_comb begin
		phase_d     = phase_q;
		token_low_d = token_low_q;
		block_rem_d = block_rem_q;
		reg_byte_d  = reg_byte_q;
		chunk_d     = chunk_q;
		consumed_d  = consumed_q;
		halted_d    = halted_q;
		grp         = '0;
		n           = 3'd0;
		tok         = {b, token_low_q};
		consumed_d  = consumed_q;
		remain      = image_bytes - consumed_q - 20'd1;
		at_end      = 1'b0;
		rem_dec     = block_rem_q - 15'd1;
		fill_inc    = {1'b0, chunk_q} + (CHUNK_W+1)'(1);
		mend        = (8'(fill_inc) >= 8'(lim - 7'd1)) || (rem_dec == 15'd0);
		if (!halted_q && (consumed_q < image_bytes)) begin
			consumed_d = consumed_q + 20'd1;
			at_end     = (consumed_d == image_bytes);
			case (phase_q)
				fsil_pkg::PH_HIGH: begin
					phase_d = fsil_pkg::PH_LOW;
					if (tok == fsil_pkg::TOK_DONE) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_DONE, 8'd0, 1'b0,
							15'd0, 2'd0);
						n = n + 3'd1;
						halted_d = 1'b1;
					end else if (tok == fsil_pkg::TOK_TRESET) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_TRESET, 8'd0, 1'b0,
							15'd0, 2'd0);
						n = n + 3'd1;
					end else if (tok == fsil_pkg::TOK_CRESET) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_CRESET, 8'd0, 1'b0,
							15'd0, 2'd0);
						n = n + 3'd1;
					end else if (tok > fsil_pkg::TOK_CRESET) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_ERROR, 8'd0, 1'b0,
							15'd0, fsil_pkg::ERR_BAD_RESET);
						n = n + 3'd1;
						halted_d = 1'b1;
					end else if (tok[15]) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_SLEEP, 8'd0, 1'b0,
							tok[14:0], 2'd0);
						n = n + 3'd1;
					end else if ({4'd0, tok} > remain) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_ERROR, 8'd0, 1'b0,
							15'd0, fsil_pkg::ERR_OVERRUN);
						n = n + 3'd1;
						halted_d = 1'b1;
					end else begin
						block_rem_d = tok[14:0];
						phase_d     = fsil_pkg::PH_REG;
					end
				end
				fsil_pkg::PH_REG: begin
					reg_byte_d  = b;
					block_rem_d = rem_dec;
					chunk_d     = '0;
					if (rem_dec == 15'd0) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_FLUSH, 8'd0, 1'b0,
							15'd0, 2'd0);
						n = n + 3'd1;
						phase_d = fsil_pkg::PH_LOW;
					end else begin
						phase_d = fsil_pkg::PH_DATA;
					end
				end
				fsil_pkg::PH_DATA: begin
					// A new message opens with the register byte.
					if (chunk_q == '0) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_I2C, reg_byte_q, 1'b0,
							15'd0, 2'd0);
						n = n + 3'd1;
					end
					grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_I2C, b, mend,
						15'd0, 2'd0);
					n = n + 3'd1;
					block_rem_d = rem_dec;
					chunk_d     = mend ? '0 : fill_inc[CHUNK_W-1:0];
					if (rem_dec == 15'd0) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_FLUSH, 8'd0, 1'b0,
							15'd0, 2'd0);
						n = n + 3'd1;
						phase_d = fsil_pkg::PH_LOW;
					end
				end
				default: begin
					if (at_end) begin
						grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_ERROR, 8'd0, 1'b0,
							15'd0, fsil_pkg::ERR_TRUNCATED);
						n = n + 3'd1;
						halted_d = 1'b1;
					end else begin
						token_low_d = b;
						phase_d     = fsil_pkg::PH_HIGH;
					end
				end
			endcase
			// The image ended cleanly on a token boundary.
			if (!halted_d && (phase_d == fsil_pkg::PH_LOW) && at_end) begin
				grp.res[n[1:0]] = fsil_pkg::mk_res(fsil_pkg::KIND_DONE, 8'd0, 1'b0,
					15'd0, 2'd0);
				n = n + 3'd1;
				halted_d = 1'b1;
			end
		end
		if (n != 3'd0) grp.res[2'(n - 3'd1)].last_of_run = 1'b1;
		grp.count = n;
	end

	// Parser state advances once per byte taken from the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fsil_pkg::PH_LOW;
			token_low_q <= '0;
			block_rem_q <= '0;
			reg_byte_q  <= '0;
			chunk_q     <= '0;
			consumed_q  <= '0;
			halted_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			token_low_q <= token_low_d;
			block_rem_q <= block_rem_d;
			reg_byte_q  <= reg_byte_d;
			chunk_q     <= chunk_d;
			consumed_q  <= consumed_d;
			halted_q    <= halted_d;
		end
	end

endmodule

[design/firmware_script_i2c_loader.sv]
`timescale 1ns / 1ps
// Each byte waits in the input stage until the queue has room; its results then
// enter the queue and raise out_valid. Throughput: one byte per cycle while out_ready
// is high and each byte makes at most one result, else set by the single output port.
// Input is held off while the eight-entry result queue has fewer than four free slots.
// Reset clears the parser, the queue and the input stage; image_bytes resets to 0
// and max_message_bytes to 64.
`include "firmware_script_i2c_loader_defines.svh"
module firmware_script_i2c_loader #(
	parameter int MAX_MESSAGE = fsil_pkg::MAX_MESSAGE_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       image_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       kind,
	output logic [7:0]                       bus_byte,
	output logic                             message_end,
	output logic [14:0]                      sleep_ms,
	output logic [1:0]                       error_code,
	output logic                             last_of_run,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fsil_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fsil_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int DEPTH = 8;
	localparam int PTR_W = $clog2(DEPTH);

	logic [19:0]              image_bytes_q;
	logic [6:0]               max_msg_q;
	logic                     v_s1;
	logic [7:0]               byte_s1;
	logic                     advance;
	fsil_pkg::result_group_t  grp;
	fsil_pkg::result_t        fifo_q [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]           count_q;
	logic                     pop;
	fsil_pkg::result_t        head;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_bytes_q <= '0;
			max_msg_q     <= fsil_pkg::MAX_MESSAGE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				fsil_pkg::REG_IMAGE_BYTES: image_bytes_q <= cfg_data;
				fsil_pkg::REG_MAX_MESSAGE: max_msg_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Input stage: the held byte is decoded once the queue has room for four results.
	assign advance  = v_s1 && (count_q <= (PTR_W+1)'(DEPTH - fsil_pkg::MAX_RESULTS));
	assign in_ready = !v_s1 || advance;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= image_byte;
		end
	end

	fsil_decode #(
		.MAX_MESSAGE(MAX_MESSAGE)
	) u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.b                (byte_s1),
		.image_bytes      (image_bytes_q),
		.max_message_bytes(max_msg_q),
		.grp              (grp)
	);

	// Result queue: up to four entries written per beat, one read per beat.
	assign pop = out_valid && out_ready;
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < fsil_pkg::MAX_RESULTS; i++) begin
				if (3'(i) < grp.count) begin
					fifo_q[wr_ptr_q + PTR_W'(i)] <= grp.res[i];
				end
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) wr_ptr_q <= wr_ptr_q + PTR_W'(grp.count);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (advance ? (PTR_W+1)'(grp.count) : '0)
				- (pop ? (PTR_W+1)'(1) : '0);
		end
	end

	// Output beat comes from the queue head.
	assign head        = fifo_q[rd_ptr_q];
	assign out_valid   = (count_q != '0);
	assign kind        = head.kind;
	assign bus_byte    = head.bus_byte;
	assign message_end = head.message_end;
	assign sleep_ms    = head.sleep_ms;
	assign error_code  = head.error_code;
	assign last_of_run = head.last_of_run;

	// Queue never overfills, and decoded results always show up at the output.
	`FSIL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= (PTR_W+1)'(DEPTH))
	`FSIL_ASSERT_NEXT(a_accept_loads_s1, in_valid && in_ready, v_s1)
	`FSIL_ASSERT_NEXT(a_results_visible, advance && (grp.count != 3'd0), out_valid)
	`FSIL_ASSERT_NOW(a_stall_only_when_held, !in_ready, v_s1 && !advance)

endmodule
